// ----- src/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// LFU cache package
// Shared types and constants for the least-frequently-used cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } lfu_state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic commit;
  } lfu_cmd_t;

endpackage

// ----- src/lfu_ctrl.sv -----
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences each beat through a search state and a commit state and owns
// the handshake on both channels.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output lfu_pkg::lfu_cmd_t ctl
);
  import lfu_pkg::*;

  lfu_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    ctl        = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        ctl.search = 1'b1;
        state_nxt  = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          ctl.commit = 1'b1;
          in_stall   = 1'b0;
          if (in_valid) begin
            ctl.load  = 1'b1;
            state_nxt = ST_SEARCH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

// ----- src/lfu_dp.sv -----
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry registers, parallel key match, free-slot search, victim selection
// tree, write-back and the result register.
// ----------------------------------------------------------------------------
module lfu_dp #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lfu_pkg::lfu_cmd_t                 ctl,
  input  logic                              in_cmd,
  input  logic [lfu_pkg::KEY_W-1:0]         in_key,
  input  logic signed [lfu_pkg::VAL_W-1:0]  in_value,
  input  logic                              cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]         cfg_wdata,
  output logic                              out_hit,
  output logic signed [lfu_pkg::VAL_W-1:0]  out_read_value,
  output logic                              out_evicted,
  output logic [lfu_pkg::KEY_W-1:0]         out_evicted_key
);
  import lfu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int NP    = 1 << IDX_W;

  typedef struct packed {
    logic                  v;
    logic [COUNT_BITS-1:0] c;
    logic [IDX_W-1:0]      r;
    logic [IDX_W-1:0]      i;
  } node_t;

  logic [ENTRIES-1:0]    valid_r;
  logic [KEY_W-1:0]      key_r   [ENTRIES];
  logic signed [VAL_W-1:0] value_r [ENTRIES];
  logic [COUNT_BITS-1:0] count_r [ENTRIES];
  logic [IDX_W-1:0]      rank_r  [ENTRIES];
  logic [OCC_W-1:0]      occ_r;
  logic [CAP_W-1:0]      capacity_r;

  logic                  item_cmd_r;
  logic [KEY_W-1:0]      item_key_r;
  logic signed [VAL_W-1:0] item_value_r;

  logic                  hit_r;
  logic                  upd_r;
  logic                  new_r;
  logic                  evict_r;
  logic [IDX_W-1:0]      slot_r;
  logic [OCC_W-1:0]      old_rank_r;

  logic [ENTRIES-1:0]    match;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      hit_rank;
  logic                  free_any;
  logic [IDX_W-1:0]      free_idx;
  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      cap_eff;
  logic                  room;
  logic                  cap_nz;
  logic                  is_new;
  logic                  use_free;
  node_t                 tree [1:2*NP-1];
  node_t                 victim;

  function automatic logic better(input node_t a, input node_t b);
    logic res;
    res = a.v && (!b.v || (a.c < b.c) || ((a.c == b.c) && (a.r > b.r)));
    return res;
  endfunction

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    hit_rank = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      match[k] = valid_r[k] && (key_r[k] == item_key_r);
      if (match[k]) begin
        hit      = 1'b1;
        hit_idx  = hit_idx | IDX_W'(k);
        hit_rank = hit_rank | rank_r[k];
      end
    end
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (!valid_r[k]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(k);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      if (k < ENTRIES) begin
        tree[NP+k] = '{v: valid_r[k], c: count_r[k], r: rank_r[k], i: IDX_W'(k)};
      end else begin
        tree[NP+k] = '0;
      end
    end
    for (int k = NP - 1; k >= 1; k--) begin
      tree[k] = better(tree[2*k], tree[2*k+1]) ? tree[2*k] : tree[2*k+1];
    end
  end

  assign victim   = tree[1];
  assign cap_ext  = CMP_W'(capacity_r);
  assign cap_eff  = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign room     = (CMP_W'(occ_r) < cap_eff) && free_any;
  assign cap_nz   = (capacity_r != '0);
  assign is_new   = (item_cmd_r == CMD_PUT) && cap_nz && !hit;
  assign use_free = room;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_cmd_r   <= in_cmd;
      item_key_r   <= in_key;
      item_value_r <= in_value;
    end
    if (ctl.search) begin
      hit_r   <= hit;
      new_r   <= is_new;
      evict_r <= is_new && !use_free;
      upd_r   <= hit ? ((item_cmd_r == CMD_GET) || cap_nz) : is_new;
      if (hit) begin
        slot_r     <= hit_idx;
        old_rank_r <= OCC_W'(hit_rank);
      end else if (use_free) begin
        slot_r     <= free_idx;
        old_rank_r <= occ_r + OCC_W'(1);
      end else begin
        slot_r     <= victim.i;
        old_rank_r <= OCC_W'(victim.r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      occ_r      <= '0;
      capacity_r <= CAP_RESET;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      if (ctl.commit && new_r) begin
        valid_r[slot_r] <= 1'b1;
        if (!evict_r) begin
          occ_r <= occ_r + OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && upd_r) begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (valid_r[k] && (IDX_W'(k) != slot_r) && (OCC_W'(rank_r[k]) < old_rank_r)) begin
          rank_r[k] <= rank_r[k] + IDX_W'(1);
        end
      end
      rank_r[slot_r] <= '0;
      if (new_r) begin
        count_r[slot_r] <= COUNT_BITS'(1);
        key_r[slot_r]   <= item_key_r;
      end else if (count_r[slot_r] != '1) begin
        count_r[slot_r] <= count_r[slot_r] + COUNT_BITS'(1);
      end
      if (item_cmd_r == CMD_PUT) begin
        value_r[slot_r] <= item_value_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_hit         <= hit_r;
      out_read_value  <= (hit_r && (item_cmd_r == CMD_GET)) ? value_r[slot_r] : '0;
      out_evicted     <= evict_r;
      out_evicted_key <= evict_r ? key_r[slot_r] : '0;
    end
  end

endmodule

// ----- src/lfu_cache_table.sv -----
// An accepted input beat is loaded, searched over all entry registers and then
// committed, which writes the entries back and fills the result register. A new
// input beat is accepted only while idle or together with that commit.
// A stalled result register holds the commit and the next input beat.
// Reset is synchronous and active low; it clears the valid bits, occupancy and
// controller state at once and sets capacity to 16.
// ----------------------------------------------------------------------------
// LFU cache table top level
// Key-value cache with least-frequently-used replacement and least-recent
// tie-break among equal use counts.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [lfu_pkg::KEY_W-1:0]         in_key,
  input  logic signed [lfu_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic signed [lfu_pkg::VAL_W-1:0]  out_read_value,
  output logic                              out_evicted,
  output logic [lfu_pkg::KEY_W-1:0]         out_evicted_key,
  input  logic                              cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]         cfg_wdata
);
  import lfu_pkg::*;

  lfu_cmd_t ctl;

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  lfu_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_value        (in_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

endmodule

// ----- src/lfu_checker.sv -----
// ----------------------------------------------------------------------------
// LFU cache port checker
// Concurrent checks on the top-level ports, bound to the cache table.
// ----------------------------------------------------------------------------
module lfu_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_hit,
  input logic signed [lfu_pkg::VAL_W-1:0]  out_read_value,
  input logic                              out_evicted,
  input logic [lfu_pkg::KEY_W-1:0]         out_evicted_key
);

  // A result beat held by the receiver keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) &&
      $stable(out_read_value) && $stable(out_evicted) && $stable(out_evicted_key))
    else $error("result beat changed while stalled");

  // Only a miss can evict.
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit)
    else $error("eviction reported on a hit");

  a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_key == '0)
    else $error("evicted key nonzero without eviction");

  // A nonzero read value only comes from a lookup hit.
  a_read_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_value != '0) |-> out_hit && !out_evicted)
    else $error("read value without a hit");

  // The cycle after a beat is taken, the block is busy searching.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted during search");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (.*);
